// ----- hdl/uctcd_pkg.sv -----
// ----------------------------------------------------------------------------
// uctcd_pkg: shared types and constants of the use count tag cache directory
// Entry count, field widths, register and request codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package uctcd_pkg;

   localparam int ENTRIES    = 16;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KEY_W      = 32;
   localparam int USES_W     = 14;
   localparam int SLOT_W     = 4;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [USES_W-1:0] LIMIT_RESET = USES_W'(9999);

   // register index (word address)
   localparam logic REG_COUNT_LIMIT = 1'b0;

   // request kind carried on tuser
   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/use_count_tag_cache_directory_top.sv -----
// ----------------------------------------------------------------------------
// use_count_tag_cache_directory_top: LFU directory of a fully associative cache
// Lookup and insert of key tags with saturating use counts, scanned one entry
// per cycle through a single shared compare unit.
// ----------------------------------------------------------------------------
//
//  channel  | direction | contents
//  ---------+-----------+-------------------------------------------------
//  req_     | in        | tuser: kind; tdata: key
//  rsp_     | out       | tdata: hit, slot, displaced (zero padded to 8 bits)
//  csr_     | in (APB)  | count_limit at byte address 0
//
//  A transaction is accepted in idle, then scans the entries in order (at most
//  ENTRIES, fewer when a lookup hits or an insert finds an empty entry) and then
//  finishes. req_tready is high only in idle. A finished result waits in the output
//  register; the next transaction scans meanwhile and holds in its finish cycle until
//  that register frees.
//  Reset empties every entry and clears all counts at once; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module use_count_tag_cache_directory_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [uctcd_pkg::KEY_W-1:0]       req_tdata,  // [31:0] key
   input  wire logic                              req_tuser,  // [0] kind
   // response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [uctcd_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // [0] hit, [4:1] slot,
                                                              // [5] displaced, [7:6] zero
   // configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [uctcd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [uctcd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [uctcd_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   import uctcd_pkg::*;

   // directory storage
   logic              entry_valid_ff [ENTRIES];
   logic              entry_valid_in [ENTRIES];
   logic [KEY_W-1:0]  entry_key_ff   [ENTRIES];
   logic [KEY_W-1:0]  entry_key_in   [ENTRIES];
   logic [USES_W-1:0] entry_uses_ff  [ENTRIES];
   logic [USES_W-1:0] entry_uses_in  [ENTRIES];

   // configuration
   logic [USES_W-1:0] count_limit_ff, count_limit_in;

   // sequencer and working registers
   state_type         state_ff, state_in;
   logic              kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  target_ff, target_in;
   logic              found_ff, found_in;
   logic [USES_W-1:0] least_ff, least_in;
   logic [USES_W-1:0] hit_uses_ff, hit_uses_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared compare unit: looks at the one entry the scan index points to
   logic              cur_valid;
   logic [KEY_W-1:0]  cur_key;
   logic [USES_W-1:0] cur_uses;
   logic              key_match;
   logic              uses_below;
   logic              last_idx;
   logic              csr_write;
   logic              out_free;

   assign cur_valid  = entry_valid_ff[idx_ff];
   assign cur_key    = entry_key_ff[idx_ff];
   assign cur_uses   = entry_uses_ff[idx_ff];
   assign key_match  = cur_valid && (cur_key == key_ff);
   assign uses_below = cur_uses < least_ff;
   assign last_idx   = (idx_ff == IDX_W'(ENTRIES - 1));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // APB: always ready, single register at word 0
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_COUNT_LIMIT)
                       ? CSR_DATA_W'(count_limit_ff) : '0;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      idx_in         = idx_ff;
      target_in      = target_ff;
      found_in       = found_ff;
      least_in       = least_ff;
      hit_uses_in    = hit_uses_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      count_limit_in = count_limit_ff;
      entry_valid_in = entry_valid_ff;
      entry_key_in   = entry_key_ff;
      entry_uses_in  = entry_uses_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration write; word addresses beyond the list are ignored
      if (csr_write && (csr_paddr[CSR_ADDR_W-1] == REG_COUNT_LIMIT)) begin
         count_limit_in = csr_pwdata[USES_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               key_in    = req_tdata;
               idx_in    = '0;
               target_in = '0;
               found_in  = 1'b0;
               least_in  = count_limit_ff;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (kind_ff == KIND_LOOKUP) begin
               // stop at the lowest matching entry
               if (key_match) begin
                  found_in    = 1'b1;
                  target_in   = idx_ff;
                  hit_uses_in = cur_uses;
                  state_in    = ST_DONE;
               end else if (last_idx) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               // first empty entry wins outright; else track the least count
               if (!cur_valid) begin
                  found_in  = 1'b1;
                  target_in = idx_ff;
                  state_in  = ST_DONE;
               end else begin
                  if (uses_below) begin
                     least_in  = cur_uses;
                     target_in = idx_ff;
                  end
                  if (last_idx) begin
                     state_in = ST_DONE;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end
         end

         ST_DONE: begin
            // hold until the output register is free, then commit
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (kind_ff == KIND_LOOKUP) begin
                  rsp_data_in = RSP_DATA_W'({1'b0,
                                             found_ff ? SLOT_W'(target_ff) : SLOT_W'(0),
                                             found_ff});
                  if (found_ff && (hit_uses_ff < count_limit_ff)) begin
                     entry_uses_in[target_ff] = hit_uses_ff + USES_W'(1);
                  end
               end else begin
                  rsp_data_in = RSP_DATA_W'({!found_ff, SLOT_W'(target_ff), 1'b0});
                  entry_valid_in[target_ff] = 1'b1;
                  entry_key_in[target_ff]   = key_ff;
                  entry_uses_in[target_ff]  = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         count_limit_ff <= LIMIT_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            entry_valid_ff[i] <= 1'b0;
            entry_uses_ff[i]  <= '0;
         end
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_limit_ff <= count_limit_in;
         entry_valid_ff <= entry_valid_in;
         entry_uses_ff  <= entry_uses_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      target_ff    <= target_in;
      found_ff     <= found_in;
      least_ff     <= least_in;
      hit_uses_ff  <= hit_uses_in;
      rsp_data_ff  <= rsp_data_in;
      entry_key_ff <= entry_key_in;
   end

endmodule

`default_nettype wire
